// File: rtl/vtp_pkg.sv
// Shared types and constants of the vertex transform and projection pipeline.
`default_nettype none

package vtp_pkg;

   // Field widths.
   localparam int CoordW   = 24;
   localparam int DiffW    = 25;
   localparam int CoeffW   = 16;
   localparam int RowW     = 48;
   localparam int ProdW    = 41;
   localparam int RotW     = 43;
   localparam int NumW     = 31;
   localparam int DepthW   = 24;
   localparam int CenterW  = 12;
   localparam int ScreenW  = 16;
   localparam int MagW     = 29;
   localparam int QuoW     = 24;
   localparam int DivSteps = 31;

   // Depth offset of 100 in Q.22.
   localparam logic signed [RotW:0] DepthOffset = 44'sd419430400;
   // Bias that keeps the depth dividend positive; it equals 45 times 2^22.
   localparam logic [29:0] BiasM = 30'd188743680;
   // floor(2^36 / 45) for the division of the depth dividend by 45.
   localparam logic [30:0] Recip45 = 31'd1527099483;
   localparam int RecipShift = 36;
   localparam logic [5:0] Scale = 6'd45;
   // Removes the bias quotient and adds one (256 in Q16.8).
   localparam logic signed [25:0] DepthBias = 26'sd4194048;
   localparam logic [DepthW-1:0] DepthMin = 24'd3;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ROW0,
      CSR_ROW1,
      CSR_ROW2,
      CSR_CAM_X,
      CSR_CAM_Y,
      CSR_CAM_Z,
      CSR_CENTER_X,
      CSR_CENTER_Y
   } csr_index_type;

   // Rotated vertex, Q.22.
   typedef struct packed {
      logic [RotW-1:0] r0;
      logic [RotW-1:0] r1;
      logic [RotW-1:0] r2;
   } rot_type;

   // Projection operands: numerators already divided by 2^12, plus the divisor.
   typedef struct packed {
      logic [NumW-1:0]   a0;
      logic [NumW-1:0]   a1;
      logic [DepthW-1:0] depth;
      logic              clamped;
   } proj_in_type;

endpackage

`default_nettype wire

// File: rtl/vtp_rotate.sv
// Camera subtraction and 3x3 matrix rotation, three pipeline stages.
`default_nettype none

module vtp_rotate
   import vtp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [2:0][CoordW-1:0]   vert,
   input  logic [2:0][RowW-1:0]     rows,
   input  logic [2:0][CoordW-1:0]   cam,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rot_type                  out_rot
);

   localparam int NStage = 3;

   logic [NStage-1:0] valid_ff;
   logic [NStage:0]   take;

   logic signed [DiffW-1:0] diff_in [3];
   logic signed [DiffW-1:0] diff_ff [3];
   logic signed [ProdW-1:0] prod_in [3][3];
   logic signed [ProdW-1:0] prod_ff [3][3];
   logic signed [RotW-1:0]  rot_in  [3];
   logic signed [RotW-1:0]  rot_ff  [3];

   // A stage takes a new beat when it is empty or its content moves on.
   always_comb begin
      take[NStage] = out_ready;
      for (int k = NStage - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k + 1];
      end
   end

   assign in_ready  = take[0];
   assign out_valid = valid_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   // Datapath of the three stages.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = $signed({vert[i][CoordW-1], vert[i]}) -
                      $signed({cam[i][CoordW-1], cam[i]});
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(rows[i][CoeffW*j +: CoeffW]) * diff_ff[j];
         end
      end
      for (int i = 0; i < 3; i++) begin
         rot_in[i] = RotW'(prod_ff[i][0]) + RotW'(prod_ff[i][1]) + RotW'(prod_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         diff_ff <= diff_in;
      end
      if (take[1]) begin
         prod_ff <= prod_in;
      end
      if (take[2]) begin
         rot_ff <= rot_in;
      end
   end

   assign out_rot.r0 = rot_ff[0];
   assign out_rot.r1 = rot_ff[1];
   assign out_rot.r2 = rot_ff[2];

endmodule

`default_nettype wire

// File: rtl/vtp_depth.sv
// Perspective divisor: offset, division by 45 through a reciprocal, clamp.
`default_nettype none

module vtp_depth
   import vtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  rot_type     in_rot,
   output logic        out_valid,
   input  logic        out_ready,
   output proj_in_type out_proj
);

   localparam int NStage = 4;

   logic [NStage-1:0] valid_ff;
   logic [NStage:0]   take;

   logic [NumW-1:0] a_ff [NStage][2];

   logic signed [RotW:0] num_sum;
   logic [29:0]          num_shift;
   logic [MagW-1:0]      m_in;
   logic [MagW-1:0]      m_ff;
   logic [MagW-1:0]      m2_ff;
   logic [59:0]          recip_prod;
   logic [QuoW-1:0]      q0_in;
   logic [QuoW-1:0]      q0_ff;
   logic [29:0]          q0_times;
   logic [29:0]          rem;
   logic [QuoW-1:0]      q_in;
   logic [QuoW-1:0]      q_ff;
   logic signed [25:0]   dq;
   logic [DepthW-1:0]    depth_in;
   logic [DepthW-1:0]    depth_ff;
   logic                 clamped_in;
   logic                 clamped_ff;

   // A stage takes a new beat when it is empty or its content moves on.
   always_comb begin
      take[NStage] = out_ready;
      for (int k = NStage - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k + 1];
      end
   end

   assign in_ready  = take[0];
   assign out_valid = valid_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   // The dividend is floored by 2^14 first, then biased so it stays positive.
   always_comb begin
      num_sum    = $signed({in_rot.r2[RotW-1], in_rot.r2}) + DepthOffset;
      num_shift  = num_sum[RotW:14];
      m_in       = MagW'(num_shift + BiasM);
      recip_prod = 60'(m_ff) * 60'(Recip45);
      q0_in      = recip_prod[59:RecipShift];
      // The reciprocal estimate is low by at most one.
      q0_times   = 30'(q0_ff) * 30'(Scale);
      rem        = 30'(m2_ff) - q0_times;
      q_in       = (rem >= 30'(Scale)) ? q0_ff + 1'b1 : q0_ff;
      dq         = $signed({2'b00, q_ff}) - DepthBias;
      if (dq < 26'sd3) begin
         depth_in   = DepthMin;
         clamped_in = 1'b1;
      end else begin
         depth_in   = dq[DepthW-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         m_ff       <= m_in;
         a_ff[0][0] <= in_rot.r0[RotW-1:12];
         a_ff[0][1] <= in_rot.r1[RotW-1:12];
      end
      if (take[1]) begin
         q0_ff   <= q0_in;
         m2_ff   <= m_ff;
         a_ff[1] <= a_ff[0];
      end
      if (take[2]) begin
         q_ff    <= q_in;
         a_ff[2] <= a_ff[1];
      end
      if (take[3]) begin
         depth_ff   <= depth_in;
         clamped_ff <= clamped_in;
         a_ff[3]    <= a_ff[2];
      end
   end

   assign out_proj.a0      = a_ff[NStage-1][0];
   assign out_proj.a1      = a_ff[NStage-1][1];
   assign out_proj.depth   = depth_ff;
   assign out_proj.clamped = clamped_ff;

endmodule

`default_nettype wire

// File: rtl/vtp_proj.sv
// Two-lane pipelined floor divider, one quotient bit per stage, then center and saturate.
`default_nettype none

module vtp_proj
   import vtp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  proj_in_type                in_proj,
   input  logic [CenterW-1:0]         center_x,
   input  logic [CenterW-1:0]         center_y,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [ScreenW-1:0]  screen_x,
   output logic signed [ScreenW-1:0]  screen_y,
   output logic [DepthW-1:0]          depth,
   output logic                       depth_clamped
);

   // Magnitude stage, one stage per quotient bit, sign fix, output register.
   localparam int NStage = DivSteps + 3;

   typedef struct packed {
      logic [1:0]             neg;
      logic [1:0][DepthW-1:0] rem;
      logic [1:0][NumW-1:0]   quo;
      logic [DepthW-1:0]      dvs;
      logic                   clamped;
   } stage_type;

   logic [NStage-1:0] valid_ff;
   logic [NStage:0]   take;

   stage_type stg_in [DivSteps+1];
   stage_type stg_ff [DivSteps+1];

   logic signed [NumW:0]      qs_in [2];
   logic signed [NumW:0]      qs_ff [2];
   logic [DepthW-1:0]         fix_depth_ff;
   logic                      fix_clamped_ff;
   logic [1:0][CenterW-1:0]   center;
   logic signed [NumW+1:0]    sum [2];
   logic [1:0][ScreenW-1:0]   screen_in;
   logic [1:0][ScreenW-1:0]   screen_ff;
   logic [DepthW-1:0]         out_depth_ff;
   logic                      out_clamped_ff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   function automatic stage_type div_step(input stage_type s);
      stage_type         r;
      logic [DepthW:0]   t;
      r = s;
      for (int l = 0; l < 2; l++) begin
         t = {s.rem[l], s.quo[l][NumW-1]};
         if (t >= {1'b0, s.dvs}) begin
            t = t - {1'b0, s.dvs};
            r.quo[l] = {s.quo[l][NumW-2:0], 1'b1};
         end else begin
            r.quo[l] = {s.quo[l][NumW-2:0], 1'b0};
         end
         r.rem[l] = t[DepthW-1:0];
      end
      return r;
   endfunction

   // A stage takes a new beat when it is empty or its content moves on.
   always_comb begin
      take[NStage] = out_ready;
      for (int k = NStage - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k + 1];
      end
   end

   assign in_ready  = take[0];
   assign out_valid = valid_ff[NStage-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NStage; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   // Magnitudes enter the divider; the signs ride along.
   always_comb begin
      stg_in[0].neg     = {in_proj.a1[NumW-1], in_proj.a0[NumW-1]};
      stg_in[0].quo[0]  = in_proj.a0[NumW-1] ? NumW'(0) - in_proj.a0 : in_proj.a0;
      stg_in[0].quo[1]  = in_proj.a1[NumW-1] ? NumW'(0) - in_proj.a1 : in_proj.a1;
      stg_in[0].rem     = '0;
      stg_in[0].dvs     = in_proj.depth;
      stg_in[0].clamped = in_proj.clamped;
      for (int k = 1; k <= DivSteps; k++) begin
         stg_in[k] = div_step(stg_ff[k - 1]);
      end
   end

   // Floor toward minus infinity: a negative quotient with remainder drops by one.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (!stg_ff[DivSteps].neg[l]) begin
            qs_in[l] = $signed({1'b0, stg_ff[DivSteps].quo[l]});
         end else if (stg_ff[DivSteps].rem[l] != '0) begin
            qs_in[l] = $signed(~{1'b0, stg_ff[DivSteps].quo[l]});
         end else begin
            qs_in[l] = -$signed({1'b0, stg_ff[DivSteps].quo[l]});
         end
      end
   end

   // Add the screen center and saturate to 16 bits.
   assign center[0] = center_x;
   assign center[1] = center_y;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sum[l] = (NumW+2)'($signed({1'b0, center[l]})) + (NumW+2)'(qs_ff[l]);
         if (sum[l] > (NumW+2)'(32767)) begin
            screen_in[l] = 16'h7FFF;
         end else if (sum[l] < -(NumW+2)'(32768)) begin
            screen_in[l] = 16'h8000;
         end else begin
            screen_in[l] = sum[l][ScreenW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivSteps; k++) begin
         if (take[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
      if (take[DivSteps + 1]) begin
         qs_ff          <= qs_in;
         fix_depth_ff   <= stg_ff[DivSteps].dvs;
         fix_clamped_ff <= stg_ff[DivSteps].clamped;
      end
      if (take[DivSteps + 2]) begin
         screen_ff      <= screen_in;
         out_depth_ff   <= fix_depth_ff;
         out_clamped_ff <= fix_clamped_ff;
      end
   end

   assign screen_x      = $signed(screen_ff[0]);
   assign screen_y      = $signed(screen_ff[1]);
   assign depth         = out_depth_ff;
   assign depth_clamped = out_clamped_ff;

endmodule

`default_nettype wire

// File: rtl/vertex_transform_project_top.sv
// Top level: configuration registers and the transform, depth and projection pipeline.
//
// Vertices arrive on the req_ channel (valid/ready), one Q16.8 vertex per beat.
// Each beat yields exactly one rsp_ beat carrying the screen column and row in
// whole pixels, the clamped Q16.8 depth and a flag set when depth was raised.
// Registers are written on the csr_ channel, which is always ready; write them
// only while no vertex is in flight.
// An accepted request passes through subtraction and rotation, depth division
// by 45, and projection with its one-bit-per-stage restoring divider.
// Throughput is one vertex per cycle while rsp_ready is high. Every stage
// carries a valid bit and loads when it is empty or its content moves on, so
// bubbles are filled while the response side is stalled; a stall holds each
// beat in place, none is lost.
// Reset clears the valid bits and loads the identity matrix, a camera at the
// origin and a screen center of zero.
`default_nettype none

module vertex_transform_project_top
   import vtp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [CoordW-1:0]   req_vert_x,
   input  logic signed [CoordW-1:0]   req_vert_y,
   input  logic signed [CoordW-1:0]   req_vert_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ScreenW-1:0]  rsp_screen_x,
   output logic signed [ScreenW-1:0]  rsp_screen_y,
   output logic [DepthW-1:0]          rsp_depth,
   output logic                       rsp_depth_clamped,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [RowW-1:0]            csr_wdata
);

   logic [2:0][RowW-1:0]    row_ff;
   logic [2:0][CoordW-1:0]  cam_ff;
   logic [CenterW-1:0]      center_x_ff;
   logic [CenterW-1:0]      center_y_ff;

   logic [2:0][CoordW-1:0]  vert;
   logic                    rot_valid;
   logic                    rot_ready;
   rot_type                 rot;
   logic                    dep_valid;
   logic                    dep_ready;
   proj_in_type             dep;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= 48'h0000_0000_4000;
         row_ff[1]   <= 48'h0000_4000_0000;
         row_ff[2]   <= 48'h4000_0000_0000;
         cam_ff      <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0:     row_ff[0]   <= csr_wdata;
            CSR_ROW1:     row_ff[1]   <= csr_wdata;
            CSR_ROW2:     row_ff[2]   <= csr_wdata;
            CSR_CAM_X:    cam_ff[0]   <= csr_wdata[CoordW-1:0];
            CSR_CAM_Y:    cam_ff[1]   <= csr_wdata[CoordW-1:0];
            CSR_CAM_Z:    cam_ff[2]   <= csr_wdata[CoordW-1:0];
            CSR_CENTER_X: center_x_ff <= csr_wdata[CenterW-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[CenterW-1:0];
            default:      row_ff[0]   <= row_ff[0];
         endcase
      end
   end

   assign vert[0] = req_vert_x;
   assign vert[1] = req_vert_y;
   assign vert[2] = req_vert_z;

   // Camera subtraction and rotation.
   vtp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .vert      (vert),
      .rows      (row_ff),
      .cam       (cam_ff),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_rot   (rot)
   );

   // Perspective divisor.
   vtp_depth u_depth (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_rot    (rot),
      .out_valid (dep_valid),
      .out_ready (dep_ready),
      .out_proj  (dep)
   );

   // Projection to screen pixels.
   vtp_proj u_proj (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dep_valid),
      .in_ready      (dep_ready),
      .in_proj       (dep),
      .center_x      (center_x_ff),
      .center_y      (center_y_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .screen_x      (rsp_screen_x),
      .screen_y      (rsp_screen_y),
      .depth         (rsp_depth),
      .depth_clamped (rsp_depth_clamped)
   );

endmodule

`default_nettype wire
